>>> src/uptca_pkg.sv
package uptca_pkg;

  localparam int CTR_BITS = 24;
  localparam int OVF_BITS = 32;
  localparam int UPTIME_BITS = CTR_BITS + OVF_BITS;
  localparam int OP_BITS = 3;
  localparam int CH_BITS = 2;
  localparam int FIRED_BITS = 4;
  localparam int SRES_BITS = 2;
  localparam int SLEEP_CH = 0;

  localparam int IN_DATA_BITS = 80;
  localparam int OUT_DATA_BITS = 72;

  localparam logic [OP_BITS-1:0] OP_TICK = 3'd0;
  localparam logic [OP_BITS-1:0] OP_READ = 3'd1;
  localparam logic [OP_BITS-1:0] OP_SET = 3'd2;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd3;
  localparam logic [OP_BITS-1:0] OP_START = 3'd4;
  localparam logic [OP_BITS-1:0] OP_SLEEP = 3'd5;
  localparam logic [OP_BITS-1:0] OP_CANCEL = 3'd6;

  localparam logic [SRES_BITS-1:0] SRES_NONE = 2'd0;
  localparam logic [SRES_BITS-1:0] SRES_TIMED = 2'd1;
  localparam logic [SRES_BITS-1:0] SRES_CANCEL = 2'd2;

  localparam int OUT_STATUS_BIT = 56;
  localparam int OUT_ARMED_BIT = 57;
  localparam int OUT_PEND_BIT = 58;
  localparam int OUT_FIRED_LSB = 59;
  localparam int OUT_SRES_LSB = 63;

  typedef logic [CTR_BITS-1:0] ctr_t;

endpackage

>>> src/uptime_counter_with_compare_alarms.sv
// Uptime counter with compare alarms.
// Input channel in_*: one transaction per request. in_tuser carries the opcode
// (tick, read uptime, set alarm, clear alarm, start, sleep, cancel sleep);
// in_tdata carries channel, alarm time, reload interval and sleep duration.
// Output channel out_*: exactly one result transaction per request, carrying
// the 56-bit uptime after the request, status, the clear flags, the mask of
// alarms fired on a tick and the sleep outcome.
// The request is applied to the counter and compare
// state at the accepting edge and its result is valid from the next cycle.
// Throughput is one request per cycle while out_tready is high; the only
// storage between the two channels is the result register, so in_tready is
// high whenever that register is empty or being taken in the same cycle.
// When the receiver stalls, the result holds and one more request is not
// accepted until it drains.
// cfg_wr_en writes the sleep minimum at any edge; it resets to 2.
// Reset clears the counter, all compare channels and flags, and the running
// and sleeping state; no result is pending after reset.
module uptime_counter_with_compare_alarms #(
  parameter int CHANNELS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // channel[1:0], when_ticks[25:2], interval_ticks[49:26], duration_ticks[73:50]
  input  logic [uptca_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // opcode[2:0]
  input  logic [uptca_pkg::OP_BITS-1:0]         in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // uptime[55:0], status[56], was_armed[57], was_pending[58],
  // fired_mask[62:59], sleep_result[64:63]
  output logic [uptca_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [uptca_pkg::CTR_BITS-1:0]        cfg_wr_data
);

  localparam int CB = uptca_pkg::CTR_BITS;

  logic [uptca_pkg::OP_BITS-1:0] in_op;
  logic [uptca_pkg::CH_BITS-1:0] in_ch;
  logic [CB-1:0]                 in_when;
  logic [CB-1:0]                 in_ivl;
  logic [CB-1:0]                 in_dur;
  logic                          in_acc;

  assign in_op   = in_tuser;
  assign in_ch   = in_tdata[1:0];
  assign in_when = in_tdata[25:2];
  assign in_ivl  = in_tdata[49:26];
  assign in_dur  = in_tdata[73:50];

  logic [CB-1:0]                    min_r;
  logic [CB-1:0]                    tick_r, tick_nxt;
  logic [uptca_pkg::OVF_BITS-1:0]   ovf_r, ovf_nxt;
  logic [CB-1:0]                    cmp_r [CHANNELS];
  logic [CB-1:0]                    cmp_nxt [CHANNELS];
  logic [CB-1:0]                    rel_r [CHANNELS];
  logic [CB-1:0]                    rel_nxt [CHANNELS];
  logic [CHANNELS-1:0]              armed_r, armed_nxt;
  logic [CHANNELS-1:0]              pend_r, pend_nxt;
  logic                             run_r, run_nxt;
  logic                             sleep_r, sleep_nxt;

  logic                              ov_r;
  logic [uptca_pkg::UPTIME_BITS-1:0] res_up_r;
  logic                              res_st_r, res_st_nxt;
  logic                              res_wa_r, res_wa_nxt;
  logic                              res_wp_r, res_wp_nxt;
  logic [uptca_pkg::FIRED_BITS-1:0]  res_fm_r, res_fm_nxt;
  logic [uptca_pkg::SRES_BITS-1:0]   res_sr_r, res_sr_nxt;

  logic [CHANNELS-1:0] ch_sel;
  logic                ch_ok;
  logic                armed_hit;
  logic                pend_hit;

  assign in_tready = !ov_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      ch_sel[c] = (in_ch == uptca_pkg::CH_BITS'(c));
    end
  end

  assign ch_ok     = (in_ch != uptca_pkg::CH_BITS'(uptca_pkg::SLEEP_CH)) &&
                     ({1'b0, in_ch} < 3'(CHANNELS));
  assign armed_hit = |(ch_sel & armed_r);
  assign pend_hit  = |(ch_sel & pend_r);

  always_comb begin
    tick_nxt   = tick_r;
    ovf_nxt    = ovf_r;
    cmp_nxt    = cmp_r;
    rel_nxt    = rel_r;
    armed_nxt  = armed_r;
    pend_nxt   = pend_r;
    run_nxt    = run_r;
    sleep_nxt  = sleep_r;
    res_st_nxt = 1'b0;
    res_wa_nxt = 1'b0;
    res_wp_nxt = 1'b0;
    res_fm_nxt = '0;
    res_sr_nxt = uptca_pkg::SRES_NONE;
    unique case (in_op)
      uptca_pkg::OP_TICK: begin
        if (!run_r) begin
          res_st_nxt = 1'b1;
        end else begin
          tick_nxt = tick_r + 1'b1;
          if (tick_nxt == '0) begin
            ovf_nxt = ovf_r + 1'b1;
          end
          for (int c = 0; c < CHANNELS; c++) begin
            if (cmp_r[c] == tick_nxt) begin
              if (c == uptca_pkg::SLEEP_CH && sleep_r) begin
                sleep_nxt  = 1'b0;
                res_sr_nxt = uptca_pkg::SRES_TIMED;
              end else if (c != uptca_pkg::SLEEP_CH && armed_r[c]) begin
                res_fm_nxt[c] = 1'b1;
                if (rel_r[c] != '0) begin
                  cmp_nxt[c] = cmp_r[c] + rel_r[c];
                end else begin
                  armed_nxt[c] = 1'b0;
                end
              end else begin
                pend_nxt[c] = 1'b1;
              end
            end
          end
        end
      end
      uptca_pkg::OP_READ: begin
      end
      uptca_pkg::OP_SET: begin
        if (!run_r || !ch_ok || armed_hit) begin
          res_st_nxt = 1'b1;
        end else begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (ch_sel[c]) begin
              pend_nxt[c]  = 1'b0;
              cmp_nxt[c]   = in_when;
              rel_nxt[c]   = in_ivl;
              armed_nxt[c] = 1'b1;
            end
          end
        end
      end
      uptca_pkg::OP_CLEAR: begin
        if (!ch_ok) begin
          res_st_nxt = 1'b1;
        end else begin
          res_wa_nxt = armed_hit;
          res_wp_nxt = pend_hit;
          armed_nxt  = armed_r & ~ch_sel;
          pend_nxt   = pend_r & ~ch_sel;
        end
      end
      uptca_pkg::OP_START: begin
        tick_nxt  = '0;
        ovf_nxt   = '0;
        armed_nxt = '0;
        pend_nxt  = '0;
        sleep_nxt = 1'b0;
        run_nxt   = 1'b1;
      end
      uptca_pkg::OP_SLEEP: begin
        if (!run_r) begin
          res_st_nxt = 1'b1;
        end else if (in_dur < min_r) begin
          res_sr_nxt = uptca_pkg::SRES_TIMED;
        end else begin
          cmp_nxt[uptca_pkg::SLEEP_CH]  = tick_r + in_dur;
          pend_nxt[uptca_pkg::SLEEP_CH] = 1'b0;
          sleep_nxt                     = 1'b1;
        end
      end
      uptca_pkg::OP_CANCEL: begin
        if (!sleep_r) begin
          res_st_nxt = 1'b1;
        end else begin
          sleep_nxt                     = 1'b0;
          pend_nxt[uptca_pkg::SLEEP_CH] = 1'b0;
          res_sr_nxt                    = uptca_pkg::SRES_CANCEL;
        end
      end
      default: begin
        res_st_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= uptca_pkg::CTR_BITS'(2);
      tick_r  <= '0;
      ovf_r   <= '0;
      armed_r <= '0;
      pend_r  <= '0;
      run_r   <= 1'b0;
      sleep_r <= 1'b0;
      ov_r    <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        cmp_r[c] <= '0;
        rel_r[c] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        min_r <= cfg_wr_data;
      end
      if (in_acc) begin
        tick_r  <= tick_nxt;
        ovf_r   <= ovf_nxt;
        cmp_r   <= cmp_nxt;
        rel_r   <= rel_nxt;
        armed_r <= armed_nxt;
        pend_r  <= pend_nxt;
        run_r   <= run_nxt;
        sleep_r <= sleep_nxt;
        ov_r    <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_up_r <= {ovf_nxt, tick_nxt};
      res_st_r <= res_st_nxt;
      res_wa_r <= res_wa_nxt;
      res_wp_r <= res_wp_nxt;
      res_fm_r <= res_fm_nxt;
      res_sr_r <= res_sr_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, res_sr_r, res_fm_r, res_wp_r, res_wa_r, res_st_r, res_up_r};

endmodule

>>> src/uptca_checker.sv
module uptca_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [uptca_pkg::IN_DATA_BITS-1:0]  in_tdata,
  input logic [uptca_pkg::OP_BITS-1:0]       in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [uptca_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted transaction produced no result");

  a_fired_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser != uptca_pkg::OP_TICK) |=>
      out_tdata[uptca_pkg::OUT_FIRED_LSB +: uptca_pkg::FIRED_BITS] == '0)
    else $error("fired mask set on non-tick transaction");

  a_clear_ch0: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == uptca_pkg::OP_CLEAR) &&
      (in_tdata[1:0] == uptca_pkg::CH_BITS'(uptca_pkg::SLEEP_CH)) |=>
      out_tdata[uptca_pkg::OUT_STATUS_BIT] && !out_tdata[uptca_pkg::OUT_ARMED_BIT] &&
      !out_tdata[uptca_pkg::OUT_PEND_BIT])
    else $error("clear of sleep channel not rejected");

endmodule

bind uptime_counter_with_compare_alarms uptca_checker u_uptca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
